### sv/drive_enable_feedback_supervisor_defines.svh
// Assertion macros for the drive supervisor.
`ifndef DRIVE_ENABLE_FEEDBACK_SUPERVISOR_DEFINES_SVH
`define DRIVE_ENABLE_FEEDBACK_SUPERVISOR_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, clocked on clock, quiet during reset
`define DEFSUP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("supervisor assertion failed");

// next-cycle implication
`define DEFSUP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("supervisor assertion failed");

`else

`define DEFSUP_ASSERT_IMP(lbl, ante, cons)
`define DEFSUP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### sv/defsup_pkg.sv
package defsup_pkg;

   localparam int DUTY_BITS    = 10;
   localparam int SPEED_BITS   = 7;
   localparam int COUNT_BITS   = 16;
   localparam int SPEED_LIMIT  = 100;
   localparam int DUTY_FULL    = (1 << DUTY_BITS) - 1;
   localparam int SPEED_DEPTH  = 1 << SPEED_BITS;

   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_BITS     = DUTY_BITS + 5 + SPEED_BITS;
   localparam int RSP_TDATA_W  = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [SPEED_BITS-1:0] SPEED_MAX     = SPEED_BITS'(SPEED_LIMIT);
   localparam logic [COUNT_BITS-1:0] TIMEOUT_RESET = COUNT_BITS'(5000);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;

   // item kinds
   localparam logic [1:0] MODE_SPEED  = 2'd0;
   localparam logic [1:0] MODE_ENABLE = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   // reported run state
   localparam logic [1:0] RUN_OFF   = 2'd0;
   localparam logic [1:0] RUN_WAIT  = 2'd1;
   localparam logic [1:0] RUN_RUN   = 2'd2;
   localparam logic [1:0] RUN_FAULT = 2'd3;

   // register indexes
   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_LEVEL   = 1'b1;

   typedef enum logic [3:0] {
      PH_OFF   = 4'b0001,
      PH_WAIT  = 4'b0010,
      PH_RUN   = 4'b0100,
      PH_FAULT = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0]  duty;
      logic                  drive_enable;
      logic [1:0]            run_state;
      logic                  fault_latched;
      logic                  feedback_good;
      logic [SPEED_BITS-1:0] speed_now;
   } status_type;

   typedef logic [DUTY_BITS-1:0] duty_table_type [0:SPEED_DEPTH-1];

   // floor(speed * full scale / 100), codes above the limit read as the limit
   function automatic duty_table_type build_duty_table();
      duty_table_type t;
      int s;
      for (int i = 0; i < SPEED_DEPTH; i++) begin
         s = (i > SPEED_LIMIT) ? SPEED_LIMIT : i;
         t[i] = DUTY_BITS'((s * DUTY_FULL) / SPEED_LIMIT);
      end
      return t;
   endfunction

   localparam duty_table_type DUTY_TABLE = build_duty_table();

endpackage

### sv/drive_enable_feedback_supervisor.sv
// Motor drive supervisor: speed setpoint, enable line and feedback watchdog.
// req channel: one item per transfer. req_tuser carries the kind (set speed,
// set enable, tick with feedback sample); req_tdata the arguments.
// rsp channel: exactly one status item per request item, in order, showing
// duty, enable line, run state, fault latch, feedback match and speed.
// csr channel: writes timeout_ticks (index 0) and feedback_good_level
// (index 1); always ready, intended to be written while the block is idle.
// The status for an item is on rsp in the cycle after its transfer.
// Throughput: one item per cycle unless rsp stalls; the state update and the
// duty table lookup sit between the request transfer and the single result register.
// When the receiver stalls, the result register holds and req_tready drops
// until the result is taken; it rises again in the cycle rsp_tready returns.
// Reset: speed 0, disabled, off, no fault, timeout 5000 ticks, good level 0,
// result register empty.
`include "drive_enable_feedback_supervisor_defines.svh"

module drive_enable_feedback_supervisor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [6:0] speed_percent, [7] enable_request, [8] feedback_level, rest zero
   input  logic [defsup_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] mode
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // duty, drive_enable, run_state[1:0], fault_latched, feedback_good,
   // speed_now[6:0], then zero fill
   output logic [defsup_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [defsup_pkg::COUNT_BITS-1:0]    csr_data
);

   logic                              req_fire;
   logic                              rsp_valid_ff, rsp_valid_in;
   defsup_pkg::status_type            result_ff;
   defsup_pkg::status_type            status_next;
   logic [defsup_pkg::COUNT_BITS-1:0] timeout_ff;
   logic                              level_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   defsup_core u_core (
      .clock               (clock),
      .reset               (reset),
      .step_valid          (req_fire),
      .mode                (req_tuser),
      .speed_percent       (req_tdata[6:0]),
      .enable_request      (req_tdata[7]),
      .feedback_level      (req_tdata[8]),
      .timeout_ticks       (timeout_ff),
      .feedback_good_level (level_ff),
      .status_next         (status_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= status_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= defsup_pkg::TIMEOUT_RESET;
         level_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            defsup_pkg::CSR_TIMEOUT: timeout_ff <= csr_data;
            defsup_pkg::CSR_LEVEL:   level_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = defsup_pkg::RSP_TDATA_W'({result_ff.speed_now,
                                                 result_ff.feedback_good,
                                                 result_ff.fault_latched,
                                                 result_ff.run_state,
                                                 result_ff.drive_enable,
                                                 result_ff.duty});

   // fault latch and fault state always travel together
   `DEFSUP_ASSERT_IMP(a_fault_state, rsp_valid_ff,
                      result_ff.fault_latched == (result_ff.run_state == defsup_pkg::RUN_FAULT))
   // a disabled drive reports off with zero duty
   `DEFSUP_ASSERT_IMP(a_disabled_off, rsp_valid_ff && !result_ff.drive_enable,
                      result_ff.run_state == defsup_pkg::RUN_OFF && result_ff.duty == '0)
   // every accepted item leaves a result behind
   `DEFSUP_ASSERT_NXT(a_result_follows, req_fire, rsp_valid_ff)
   // stored speed never exceeds the saturation limit
   `DEFSUP_ASSERT_IMP(a_speed_limit, rsp_valid_ff,
                      result_ff.speed_now <= defsup_pkg::SPEED_MAX)

endmodule

### sv/defsup_core.sv
module defsup_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_valid,
   input  logic [1:0]                          mode,
   input  logic [defsup_pkg::SPEED_BITS-1:0]   speed_percent,
   input  logic                                enable_request,
   input  logic                                feedback_level,
   input  logic [defsup_pkg::COUNT_BITS-1:0]   timeout_ticks,
   input  logic                                feedback_good_level,
   output defsup_pkg::status_type              status_next
);

   logic [defsup_pkg::SPEED_BITS-1:0] speed_ff, speed_in;
   logic                              enabled_ff, enabled_in;
   logic                              fault_ff, fault_in;
   logic                              seen_ff, seen_in;
   logic [defsup_pkg::COUNT_BITS-1:0] count_ff, count_in;
   defsup_pkg::phase_type             phase_ff, phase_in;

   always_comb begin
      speed_in   = speed_ff;
      enabled_in = enabled_ff;
      fault_in   = fault_ff;
      seen_in    = seen_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      unique case (mode)
         defsup_pkg::MODE_SPEED: begin
            speed_in = (speed_percent > defsup_pkg::SPEED_MAX) ?
                       defsup_pkg::SPEED_MAX : speed_percent;
         end
         defsup_pkg::MODE_ENABLE: begin
            enabled_in = enable_request;
            fault_in   = 1'b0;
            count_in   = '0;
            phase_in   = enable_request ? defsup_pkg::PH_WAIT : defsup_pkg::PH_OFF;
         end
         defsup_pkg::MODE_TICK: begin
            seen_in = (feedback_level == feedback_good_level);
            if (!enabled_ff) begin
               fault_in = 1'b0;
               count_in = '0;
               phase_in = defsup_pkg::PH_OFF;
            end else if (seen_in) begin
               fault_in = 1'b0;
               count_in = '0;
               phase_in = defsup_pkg::PH_RUN;
            end else begin
               // bad sample: restart the wait from running, otherwise count on
               if (phase_ff != defsup_pkg::PH_WAIT && phase_ff != defsup_pkg::PH_FAULT) begin
                  phase_in = defsup_pkg::PH_WAIT;
                  count_in = '0;
               end else if (count_ff != defsup_pkg::COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               if (phase_in == defsup_pkg::PH_WAIT && count_in >= timeout_ticks) begin
                  fault_in = 1'b1;
                  phase_in = defsup_pkg::PH_FAULT;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status_next.duty          = enabled_in ? defsup_pkg::DUTY_TABLE[speed_in] : '0;
      status_next.drive_enable  = enabled_in;
      status_next.fault_latched = fault_in;
      status_next.feedback_good = seen_in;
      status_next.speed_now     = speed_in;
      unique case (phase_in)
         defsup_pkg::PH_OFF:   status_next.run_state = defsup_pkg::RUN_OFF;
         defsup_pkg::PH_WAIT:  status_next.run_state = defsup_pkg::RUN_WAIT;
         defsup_pkg::PH_RUN:   status_next.run_state = defsup_pkg::RUN_RUN;
         defsup_pkg::PH_FAULT: status_next.run_state = defsup_pkg::RUN_FAULT;
         default:              status_next.run_state = defsup_pkg::RUN_OFF;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= '0;
         enabled_ff <= 1'b0;
         fault_ff   <= 1'b0;
         seen_ff    <= 1'b0;
         count_ff   <= '0;
         phase_ff   <= defsup_pkg::PH_OFF;
      end else if (step_valid) begin
         speed_ff   <= speed_in;
         enabled_ff <= enabled_in;
         fault_ff   <= fault_in;
         seen_ff    <= seen_in;
         count_ff   <= count_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

### tb/sv/drive_enable_feedback_supervisor_tb.sv
`timescale 1ns / 100ps

module drive_enable_feedback_supervisor_tb;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [defsup_pkg::DUTY_BITS-1:0]  duty;
      logic                              drive_enable;
      logic [1:0]                        run_state;
      logic                              fault_latched;
      logic                              feedback_good;
      logic [defsup_pkg::SPEED_BITS-1:0] speed_now;
   } status_fields_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [defsup_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]                         req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [defsup_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                               csr_valid;
   logic                               csr_ready;
   logic                               csr_index;
   logic [defsup_pkg::COUNT_BITS-1:0]  csr_data;

   // supervisor model state, reset values
   logic [defsup_pkg::SPEED_BITS-1:0] speed_setting  = '0;
   logic                              drive_on       = 1'b0;
   logic                              fault_on       = 1'b0;
   logic [1:0]                        sup_phase      = defsup_pkg::RUN_OFF;
   logic [defsup_pkg::COUNT_BITS-1:0] bad_tick_count = '0;
   logic                              feedback_ok    = 1'b0;
   logic [defsup_pkg::COUNT_BITS-1:0] timeout_limit  = defsup_pkg::TIMEOUT_RESET;
   logic                              good_level     = 1'b0;

   status_fields_type expected_status[$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   bit                send_gaps      = 1'b1;
   bit                recv_stalls    = 1'b1;

   drive_enable_feedback_supervisor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[drive_enable_feedback_supervisor] ERROR");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (recv_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic status_fields_type advance_supervisor(input logic [1:0] mode,
                                                            input logic [6:0] spd,
                                                            input logic en,
                                                            input logic fb);
      status_fields_type s;
      int                scaled;
      case (mode)
         defsup_pkg::MODE_SPEED: begin
            speed_setting = (spd > defsup_pkg::SPEED_MAX) ? defsup_pkg::SPEED_MAX : spd;
         end
         defsup_pkg::MODE_ENABLE: begin
            drive_on       = en;
            fault_on       = 1'b0;
            bad_tick_count = '0;
            sup_phase      = en ? defsup_pkg::RUN_WAIT : defsup_pkg::RUN_OFF;
         end
         defsup_pkg::MODE_TICK: begin
            feedback_ok = (fb == good_level);
            if (!drive_on) begin
               fault_on       = 1'b0;
               bad_tick_count = '0;
               sup_phase      = defsup_pkg::RUN_OFF;
            end else if (feedback_ok) begin
               fault_on       = 1'b0;
               bad_tick_count = '0;
               sup_phase      = defsup_pkg::RUN_RUN;
            end else begin
               // leaving running restarts the count; otherwise count up, saturating
               if (sup_phase != defsup_pkg::RUN_WAIT && sup_phase != defsup_pkg::RUN_FAULT) begin
                  sup_phase      = defsup_pkg::RUN_WAIT;
                  bad_tick_count = '0;
               end else if (bad_tick_count != defsup_pkg::COUNT_MAX) begin
                  bad_tick_count = bad_tick_count + 1'b1;
               end
               if (sup_phase == defsup_pkg::RUN_WAIT && bad_tick_count >= timeout_limit) begin
                  fault_on  = 1'b1;
                  sup_phase = defsup_pkg::RUN_FAULT;
               end
            end
         end
         default: begin
         end
      endcase
      scaled = (int'(speed_setting) * defsup_pkg::DUTY_FULL) / defsup_pkg::SPEED_LIMIT;
      s.duty          = drive_on ? scaled[defsup_pkg::DUTY_BITS-1:0] : '0;
      s.drive_enable  = drive_on;
      s.run_state     = sup_phase;
      s.fault_latched = fault_on;
      s.feedback_good = feedback_ok;
      s.speed_now     = speed_setting;
      return s;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // rsp_tdata from bit 0: duty[9:0], drive_enable, run_state[1:0], fault_latched,
   // feedback_good, speed_now[6:0]
   always @(posedge clock) begin : status_check
      status_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            $error("status transfer with none expected: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            check_field("duty", 32'(want.duty), 32'(rsp_tdata[9:0]));
            check_field("drive_enable", 32'(want.drive_enable), 32'(rsp_tdata[10]));
            check_field("run_state", 32'(want.run_state), 32'(rsp_tdata[12:11]));
            check_field("fault_latched", 32'(want.fault_latched), 32'(rsp_tdata[13]));
            check_field("feedback_good", 32'(want.feedback_good), 32'(rsp_tdata[14]));
            check_field("speed_now", 32'(want.speed_now), 32'(rsp_tdata[21:15]));
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic [1:0] mode, input logic [6:0] spd,
                            input logic en, input logic fb);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {7'b0, fb, en, spd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_status.push_back(advance_supervisor(mode, spd, en, fb));
      @(negedge clock);
   endtask

   task automatic send_random_fields(input logic [1:0] mode);
      send_item(mode, 7'($urandom_range(0, 127)), 1'($urandom), 1'($urandom));
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic index,
                            input logic [defsup_pkg::COUNT_BITS-1:0] value);
      wait_idle();
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == defsup_pkg::CSR_TIMEOUT)
         timeout_limit = value;
      else
         good_level = value[0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_ticks(input int n, input logic fb);
      for (int i = 0; i < n; i++)
         send_item(defsup_pkg::MODE_TICK, 7'($urandom_range(0, 127)), 1'($urandom), fb);
   endtask

   // reset state, speed saturation, enable/disable, ticks while disabled
   task automatic test_basic_commands();
      send_item(MODE_UNUSED, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_SPEED, 7'd127, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b1, 1'b0);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b1, 1'b0);
      send_item(defsup_pkg::MODE_SPEED, 7'd100, 1'b0, 1'b1);
      send_item(defsup_pkg::MODE_SPEED, 7'd101, 1'b1, 1'b0);
      send_item(defsup_pkg::MODE_SPEED, 7'd1, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_SPEED, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_SPEED, 7'd57, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd127, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b1);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b1, 1'b1);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b1, 1'b0);
      send_item(MODE_UNUSED, 7'd127, 1'b1, 1'b1);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b1);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_SPEED, 7'd99, 1'b0, 1'b0);
      wait_idle();
   endtask

   // default timeout: a short run of bad ticks keeps waiting, good feedback recovers
   task automatic test_default_timeout();
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b1, 1'b0);
      send_ticks(20, 1'b1);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0);
      send_ticks(3, 1'b1);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b1, 1'b0);
      wait_idle();
   endtask

   // zero timeout faults on the first bad tick, from waiting and from running
   task automatic test_zero_timeout();
      write_reg(defsup_pkg::CSR_TIMEOUT, 16'd0);
      write_reg(defsup_pkg::CSR_LEVEL, 16'd1);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b1, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b1);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b0, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b0);
      wait_idle();
   endtask

   // largest timeout: a run of bad ticks stays waiting without a fault
   task automatic test_full_timeout();
      write_reg(defsup_pkg::CSR_TIMEOUT, 16'hFFFF);
      send_item(defsup_pkg::MODE_ENABLE, 7'd0, 1'b1, 1'b0);
      send_ticks(20, 1'b0);
      send_item(defsup_pkg::MODE_TICK, 7'd0, 1'b0, 1'b1);
      wait_idle();
   endtask

   // sender holds off until every status has come back
   task automatic test_one_at_a_time();
      for (int i = 0; i < 6; i++) begin
         send_random_fields(2'($urandom_range(0, 2)));
         wait_idle();
      end
   endtask

   task automatic test_random_phase(input logic [defsup_pkg::COUNT_BITS-1:0] timeout,
                                    input logic level, input int n);
      int pick;
      int bad_pct;
      int burst;
      write_reg(defsup_pkg::CSR_TIMEOUT, timeout);
      write_reg(defsup_pkg::CSR_LEVEL, 16'(level));
      bad_pct = $urandom_range(20, 90);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_item(defsup_pkg::MODE_TICK, 7'($urandom_range(0, 127)), 1'($urandom),
                      ($urandom_range(0, 99) < bad_pct) ? ~level : level);
         end else if (pick < 58) begin
            // run of bad ticks to push the watchdog towards its limit
            burst = $urandom_range(1, 12);
            send_ticks(burst, ~level);
            i += burst - 1;
         end else if (pick < 75) begin
            send_random_fields(defsup_pkg::MODE_SPEED);
         end else if (pick < 92) begin
            send_item(defsup_pkg::MODE_ENABLE, 7'($urandom_range(0, 127)),
                      $urandom_range(0, 3) != 0, 1'($urandom));
         end else begin
            send_random_fields(MODE_UNUSED);
         end
      end
      wait_idle();
   endtask

   task automatic test_random();
      test_random_phase(16'd0, 1'b0, 165);
      test_random_phase(16'd1, 1'b1, 165);
      test_random_phase(16'd2, 1'b0, 165);
      test_random_phase(16'd3, 1'b1, 165);
      test_random_phase(16'($urandom_range(4, 12)), 1'($urandom), 165);
      test_random_phase(16'hFFFF, 1'($urandom), 165);
      test_random_phase(16'($urandom_range(0, 20)), 1'b0, 165);
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      test_random_phase(16'd5, 1'b1, 165);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = defsup_pkg::MODE_SPEED;
      csr_valid  = 1'b0;
      csr_index  = defsup_pkg::CSR_TIMEOUT;
      csr_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_commands();
      test_default_timeout();
      test_zero_timeout();
      test_full_timeout();
      test_one_at_a_time();
      test_random();

      wait_idle();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("[drive_enable_feedback_supervisor] OK");
      else
         $display("[drive_enable_feedback_supervisor] ERROR");
      $finish;
   end

endmodule

### drive_enable_feedback_supervisor.f
+incdir+sv
sv/defsup_pkg.sv
sv/defsup_core.sv
sv/drive_enable_feedback_supervisor.sv
tb/sv/drive_enable_feedback_supervisor_tb.sv
